FILE: rtl/fed_pkg.sv
// shared types, constants and arithmetic helpers for the feedback echo delay
package fed_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 18;
  localparam int DEPTH      = 131072;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int FILL_W     = ADDR_W + 1;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 18;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W      = SAMPLE_W + 2;
  localparam int FRAC_W     = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [FILL_W-1:0]          fill_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FEEDBACK_GAIN,
    REG_DRY_GAIN,
    REG_WET_GAIN,
    REG_DELAY_LENGTH
  } cfg_reg_t;

  localparam gain_t GAIN_ONE          = gain_t'(1 << FRAC_W);
  localparam gain_t FEEDBACK_GAIN_RST = gain_t'(9830);
  localparam gain_t DRY_GAIN_RST      = gain_t'(32768);
  localparam gain_t WET_GAIN_RST      = gain_t'(16384);
  localparam len_t  DELAY_LENGTH_RST  = len_t'(24000);
  localparam len_t  LEN_MAX           = len_t'(DEPTH);
  localparam len_t  LEN_MIN           = len_t'(1);

  localparam sum_t SUM_MAX = sum_t'((1 << (SAMPLE_W - 1)) - 1);
  localparam sum_t SUM_MIN = ~SUM_MAX;

  function automatic gain_t clamp_gain(gain_t g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  function automatic prod_t mul_gain(sample_t s, gain_t g);
    return prod_t'(s) * prod_t'($signed({1'b0, g}));
  endfunction

  function automatic sum_t shr_frac(prod_t p);
    return sum_t'(p >>> FRAC_W);
  endfunction

  function automatic sample_t sat_sample(sum_t v);
    sample_t r;
    if (v > SUM_MAX) begin
      r = sample_t'(SUM_MAX);
    end else if (v < SUM_MIN) begin
      r = sample_t'(SUM_MIN);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

endpackage

FILE: rtl/fed_if.sv
// stream and configuration channel interfaces of the feedback echo delay
interface fed_in_if;
  logic              valid;
  logic              ready;
  fed_pkg::sample_t  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fed_out_if;
  logic              valid;
  logic              ready;
  fed_pkg::sample_t  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface fed_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fed_pkg::CFG_ADDR_W-1:0]    addr;
  logic [fed_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/fed_ram.sv
// generic simple dual-port ram with registered read data
module fed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/feedback_echo_delay.sv
// top level of the feedback echo delay
// Mono feedback echo over a 131072-entry circular sample store. One sample beat is taken
// every clock cycle when the output side keeps up; each result passes the store read
// stage, the feedback write and mix products stage and the output register before it
// is presented. The rate is set by the store RAM, which does one read and one write per
// cycle; the write of a sample and the read of the next one meet in the same cycle and
// the newest write is forwarded.
// No clearing pass is run after reset: a fill count marks the entries written so far and
// every other entry reads as zero, so samples are accepted from the first cycle after reset.
// Configuration beats are always taken and should only be sent while the block is idle.
module feedback_echo_delay (
  input  logic       clk,
  input  logic       rst_n,
  fed_in_if.sink     in_s,
  fed_out_if.source  out_s,
  fed_cfg_if.sink    cfg_s
);

  fed_pkg::gain_t   fb_gain_r;
  fed_pkg::gain_t   dry_gain_r;
  fed_pkg::gain_t   wet_gain_r;
  fed_pkg::len_t    delay_len_r;
  fed_pkg::len_t    len_eff;

  fed_pkg::addr_t   pos_r;
  fed_pkg::fill_t   fill_r;
  fed_pkg::fill_t   pos_inc;

  logic             en;
  logic             acc;

  logic             s1_v_r;
  fed_pkg::sample_t s1_x_r;
  fed_pkg::addr_t   s1_addr_r;
  logic             s1_fresh_r;

  logic [fed_pkg::SAMPLE_W-1:0] rd_data;
  fed_pkg::sample_t y;
  fed_pkg::sample_t fb;
  logic             we;
  logic             fwd_hit;

  logic             lw_v_r;
  fed_pkg::addr_t   lw_addr_r;
  fed_pkg::sample_t lw_data_r;

  logic             s2_v_r;
  fed_pkg::prod_t   s2_dp_r;
  fed_pkg::prod_t   s2_wp_r;

  logic             out_v_r;
  fed_pkg::sample_t out_data_r;

  // configuration
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_gain_r   <= fed_pkg::FEEDBACK_GAIN_RST;
      dry_gain_r  <= fed_pkg::DRY_GAIN_RST;
      wet_gain_r  <= fed_pkg::WET_GAIN_RST;
      delay_len_r <= fed_pkg::DELAY_LENGTH_RST;
    end else if (cfg_s.valid) begin
      case (fed_pkg::cfg_reg_t'(cfg_s.addr))
        fed_pkg::REG_FEEDBACK_GAIN: fb_gain_r   <= fed_pkg::GAIN_W'(cfg_s.data);
        fed_pkg::REG_DRY_GAIN:      dry_gain_r  <= fed_pkg::GAIN_W'(cfg_s.data);
        fed_pkg::REG_WET_GAIN:      wet_gain_r  <= fed_pkg::GAIN_W'(cfg_s.data);
        fed_pkg::REG_DELAY_LENGTH:  delay_len_r <= fed_pkg::LEN_W'(cfg_s.data);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (delay_len_r < fed_pkg::LEN_MIN) begin
      len_eff = fed_pkg::LEN_MIN;
    end else if (delay_len_r > fed_pkg::LEN_MAX) begin
      len_eff = fed_pkg::LEN_MAX;
    end else begin
      len_eff = delay_len_r;
    end
  end

  // handshake and position
  assign en         = !out_v_r || out_s.ready;
  assign acc        = in_s.valid && en;
  assign in_s.ready = en;
  assign pos_inc    = {1'b0, pos_r} + fed_pkg::fill_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else if (acc) begin
      if (fed_pkg::LEN_W'(pos_inc) >= len_eff) begin
        pos_r <= '0;
      end else begin
        pos_r <= pos_inc[fed_pkg::ADDR_W-1:0];
      end
      if ({1'b0, pos_r} == fill_r) begin
        fill_r <= fill_r + fed_pkg::fill_t'(1);
      end
    end
  end

  // store read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x_r     <= in_s.sample_in;
      s1_addr_r  <= pos_r;
      s1_fresh_r <= ({1'b0, pos_r} < fill_r);
    end
  end

  fed_ram #(
    .WIDTH (fed_pkg::SAMPLE_W),
    .DEPTH (fed_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (s1_addr_r),
    .wr_data (fb),
    .re      (acc),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  // feedback write with forwarding of the previous write
  assign fwd_hit = lw_v_r && (lw_addr_r == s1_addr_r);

  always_comb begin
    if (!s1_fresh_r) begin
      y = '0;
    end else if (fwd_hit) begin
      y = lw_data_r;
    end else begin
      y = $signed(rd_data);
    end
  end

  assign fb = fed_pkg::sat_sample(fed_pkg::sum_t'(s1_x_r) +
              fed_pkg::shr_frac(fed_pkg::mul_gain(y, fed_pkg::clamp_gain(fb_gain_r))));
  assign we = s1_v_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (we) begin
      lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lw_addr_r <= s1_addr_r;
      lw_data_r <= fb;
    end
  end

  // mix products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      s2_dp_r <= fed_pkg::mul_gain(s1_x_r, fed_pkg::clamp_gain(dry_gain_r));
      s2_wp_r <= fed_pkg::mul_gain(y, fed_pkg::clamp_gain(wet_gain_r));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_v_r) begin
      out_data_r <= fed_pkg::sat_sample(fed_pkg::shr_frac(s2_dp_r) +
                                        fed_pkg::shr_frac(s2_wp_r));
    end
  end

  assign out_s.valid      = out_v_r;
  assign out_s.sample_out = out_data_r;

endmodule
